// ===== rtl/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared constants, command and status types for the difficulty retarget block.
// ----------------------------------------------------------------------------
package pdr_pkg;

   // target width; storage is always four 64-bit words
   localparam int TARGET_BITS = 256;
   localparam int BIG_BITS    = 256;
   localparam int WORD_BITS   = 64;

   // bits of the big value that lie below TARGET_BITS
   localparam logic [BIG_BITS-1:0] TGT_MASK = {BIG_BITS{1'b1}} >> (BIG_BITS - TARGET_BITS);

   // pow limit 0x7fffff shifted to the top of the target
   localparam logic [BIG_BITS-1:0] LIMIT_VAL =
      (BIG_BITS'(24'h7fffff) << (TARGET_BITS - 24)) & TGT_MASK;

   // ratio halving threshold
   localparam logic [39:0] HALVE_LIMIT = 40'd1000000;

   // configuration registers
   localparam logic [31:0] PERIOD_RESET = 32'd1209600;
   localparam logic [7:0]  FACTOR_RESET = 8'd4;
   localparam logic        CSR_IDX_PERIOD = 1'b0;
   localparam logic        CSR_IDX_FACTOR = 1'b1;

   // iteration counts (divider retires 4 quotient bits a cycle)
   localparam int CNT_W       = 6;
   localparam int DIV_RADIX   = 4;
   localparam int MINT_CYCLES = 32 / DIV_RADIX;
   localparam int DIV_CYCLES  = BIG_BITS / DIV_RADIX;
   localparam int MUL_CYCLES  = BIG_BITS / 32;

   // datapath operations
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_PREP,
      DP_DIV,
      DP_CLAMP,
      DP_HALVE,
      DP_ORDER,
      DP_MUL,
      DP_FIX,
      DP_LIMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_load;
   } pdr_cmd_type;

   typedef struct packed {
      logic zero;
      logic halve_done;
      logic mul_first;
   } pdr_status_type;

   // controller states
   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_PREP  = 11'b00000000010,
      ST_MINT  = 11'b00000000100,
      ST_CLAMP = 11'b00000001000,
      ST_HALVE = 11'b00000010000,
      ST_ORDER = 11'b00000100000,
      ST_MUL   = 11'b00001000000,
      ST_DIV   = 11'b00010000000,
      ST_FIX   = 11'b00100000000,
      ST_LIMIT = 11'b01000000000,
      ST_DONE  = 11'b10000000000
   } pdr_state_type;

endpackage

// ===== rtl/pdr_datapath.sv =====
// ----------------------------------------------------------------------------
// pdr_datapath
// Operand registers, shared 4-bit-per-cycle divider, 32x32 multiply step,
// clamp, ratio halving and limit compare.
// ----------------------------------------------------------------------------
module pdr_datapath import pdr_pkg::*; (
   input  logic                 clock,
   input  pdr_cmd_type          cmd,
   input  logic [BIG_BITS-1:0]  in_target,
   input  logic [31:0]          in_elapsed,
   input  logic [31:0]          cfg_period,
   input  logic [7:0]           cfg_factor,
   output pdr_status_type       status,
   output logic [BIG_BITS-1:0]  result
);

   logic [BIG_BITS-1:0] t_ff, t_in;
   logic [BIG_BITS-1:0] q_ff, q_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         d_ff, d_in;
   logic [31:0]         m_ff, m_in;
   logic [31:0]         carry_ff, carry_in;
   logic [31:0]         et_ff, et_in;
   logic [31:0]         per_ff, per_in;
   logic [7:0]          fac_ff, fac_in;
   logic [39:0]         maxt_ff, maxt_in;
   logic [39:0]         num_ff, num_in;
   logic [31:0]         den_ff, den_in;
   logic                zero_ff, zero_in;
   logic                mul_first_ff, mul_first_in;

   // divider step signals
   logic [31:0]         div_rem;
   logic [32:0]         div_r2;
   logic [BIG_BITS-1:0] div_q;

   // other combinational terms
   logic [63:0]         mul_p;
   logic signed [41:0]  et_x;
   logic signed [41:0]  maxt_x;
   logic [31:0]         num32;
   logic [31:0]         den32;
   logic [BIG_BITS-1:0] q_masked;
   logic                halve_go;

   // restoring division, four quotient bits a cycle
   always_comb begin
      div_rem = rem_ff;
      div_q   = q_ff;
      div_r2  = '0;
      for (int k = 0; k < DIV_RADIX; k++) begin
         div_r2 = {div_rem, div_q[BIG_BITS-1]};
         div_q  = {div_q[BIG_BITS-2:0], 1'b0};
         if (div_r2 >= {1'b0, d_ff}) begin
            div_rem  = 32'(div_r2 - {1'b0, d_ff});
            div_q[0] = 1'b1;
         end else begin
            div_rem = div_r2[31:0];
         end
      end
   end

   // one 32-bit chunk of the big multiply
   assign mul_p = 64'(q_ff[31:0]) * 64'(m_ff) + 64'(carry_ff);

   // clamp and ordering terms
   assign et_x     = 42'(signed'(et_ff));
   assign maxt_x   = signed'({2'b00, maxt_ff});
   assign num32    = num_ff[31:0];
   assign den32    = (den_ff == 32'd0) ? 32'd1 : den_ff;
   assign q_masked = q_ff & TGT_MASK;
   assign halve_go = (num_ff > HALVE_LIMIT) && (den_ff > 32'd1);

   // next-state decode per operation
   always_comb begin
      t_in         = t_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      d_in         = d_ff;
      m_in         = m_ff;
      carry_in     = carry_ff;
      et_in        = et_ff;
      per_in       = per_ff;
      fac_in       = fac_ff;
      maxt_in      = maxt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      zero_in      = zero_ff;
      mul_first_in = mul_first_ff;
      unique case (cmd.op)
         DP_NOP: begin
         end
         DP_LOAD: begin
            t_in    = in_target & TGT_MASK;
            zero_in = ((in_target & TGT_MASK) == '0);
            et_in   = in_elapsed;
            per_in  = (cfg_period == 32'd0) ? 32'd1 : cfg_period;
            fac_in  = (cfg_factor == 8'd0) ? 8'd1 : cfg_factor;
         end
         DP_PREP: begin
            // period / factor runs through the divider from the top bits
            q_in    = {per_ff, {(BIG_BITS-32){1'b0}}};
            rem_in  = '0;
            d_in    = {24'd0, fac_ff};
            maxt_in = 40'(per_ff) * 40'(fac_ff);
         end
         DP_DIV: begin
            q_in   = div_q;
            rem_in = div_rem;
         end
         DP_CLAMP: begin
            if (et_x > maxt_x) begin
               num_in = maxt_ff;
            end else if (signed'({1'b0, et_ff}) < signed'({1'b0, q_ff[31:0]})
                         || et_ff[31]) begin
               num_in = {8'd0, q_ff[31:0]};
            end else begin
               num_in = {8'd0, et_ff};
            end
            den_in = per_ff;
         end
         DP_HALVE: begin
            if (halve_go) begin
               num_in = {1'b0, num_ff[39:1]};
               den_in = {1'b0, den_ff[31:1]};
            end
         end
         DP_ORDER: begin
            m_in         = num32;
            d_in         = den32;
            mul_first_in = (num32 > den32);
            q_in         = t_ff;
            rem_in       = '0;
            carry_in     = '0;
         end
         DP_MUL: begin
            q_in     = {mul_p[31:0], q_ff[BIG_BITS-1:32]};
            carry_in = mul_p[63:32];
         end
         DP_FIX: begin
            q_in     = q_masked;
            rem_in   = '0;
            carry_in = '0;
         end
         DP_LIMIT: begin
            q_in = (q_masked > LIMIT_VAL) ? LIMIT_VAL : q_masked;
         end
         default: begin
         end
      endcase
   end

   // operand registers
   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      d_ff         <= d_in;
      m_ff         <= m_in;
      carry_ff     <= carry_in;
      et_ff        <= et_in;
      per_ff       <= per_in;
      fac_ff       <= fac_in;
      maxt_ff      <= maxt_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      zero_ff      <= zero_in;
      mul_first_ff <= mul_first_in;
   end

   assign status.zero       = zero_ff;
   assign status.halve_done = !halve_go;
   assign status.mul_first  = mul_first_ff;
   assign result            = zero_ff ? '0 : q_ff;

endmodule

// ===== rtl/pdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdr_ctrl
// Sequencer for the retarget: clamp, halving, multiply/divide order, limit.
// ----------------------------------------------------------------------------
module pdr_ctrl import pdr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           rsp_free,
   input  pdr_status_type status,
   output logic           req_ready,
   output pdr_cmd_type    cmd
);

   pdr_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             second_ff, second_in;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      second_in    = second_ff;
      cmd.op       = DP_NOP;
      cmd.out_load = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.op   = DP_PREP;
               cnt_in   = '0;
               state_in = ST_MINT;
            end
         end
         ST_MINT: begin
            cmd.op = DP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MINT_CYCLES - 1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.op   = DP_CLAMP;
            state_in = ST_HALVE;
         end
         ST_HALVE: begin
            cmd.op = DP_HALVE;
            if (status.halve_done) begin
               state_in = ST_ORDER;
            end
         end
         ST_ORDER: begin
            cmd.op    = DP_ORDER;
            cnt_in    = '0;
            second_in = 1'b0;
            state_in  = ST_FIX;
         end
         ST_FIX: begin
            // picks the next operation from the phase and the ratio order
            cmd.op = second_ff ? DP_FIX : DP_NOP;
            cnt_in = '0;
            if (status.mul_first != second_ff) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_MUL: begin
            cmd.op = DP_MUL;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_CYCLES - 1)) begin
               second_in = 1'b1;
               state_in  = second_ff ? ST_LIMIT : ST_FIX;
            end
         end
         ST_DIV: begin
            cmd.op = DP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
               second_in = 1'b1;
               state_in  = second_ff ? ST_LIMIT : ST_FIX;
            end
         end
         ST_LIMIT: begin
            cmd.op   = DP_LIMIT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         second_ff <= second_in;
      end
   end

endmodule

// ===== rtl/pow_difficulty_retarget.sv =====
// ----------------------------------------------------------------------------
// pow_difficulty_retarget
// Scales a 256-bit proof-of-work target by the clamped ratio of measured to
// desired interval time and clamps it to the pow limit.
// ----------------------------------------------------------------------------
// One item at a time; a zero target skips the arithmetic and goes straight to
// the result. Most of the time goes into the shared restoring divider, which
// retires four quotient bits a cycle, first for period / factor and then for
// the 256-bit divide. The multiply runs through one 32x32 multiplier, and the
// ratio halving does one halving step per cycle. The finished result sits in an
// output register, so the next item can be taken while it waits on rsp_tready.
// target_period and adjust_factor may be written only while the block is idle.
module pow_difficulty_retarget import pdr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: old_target_w0, old_target_w1, old_target_w2, old_target_w3,
   // elapsed_time (lowest bit up)
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,
   // rsp_tdata: new_target_w0, new_target_w1, new_target_w2, new_target_w3
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata,
   // rsp_tuser: target_valid
   output logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [31:0]         period_ff, period_in;
   logic [7:0]          factor_ff, factor_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [255:0]        rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;
   logic                rsp_free;
   pdr_cmd_type         cmd;
   pdr_status_type      status;
   logic [BIG_BITS-1:0] result;

   // configuration registers
   always_comb begin
      period_in = period_ff;
      factor_in = factor_ff;
      if (csr_we) begin
         unique case (csr_index[0])
            CSR_IDX_PERIOD: period_in = csr_wdata;
            CSR_IDX_FACTOR: factor_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         factor_ff <= FACTOR_RESET;
      end else begin
         period_ff <= period_in;
         factor_ff <= factor_in;
      end
   end

   // output register
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
         rsp_user_in  = !status.zero;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   pdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .rsp_free  (rsp_free),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   pdr_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .in_target  (req_tdata[255:0]),
      .in_elapsed (req_tdata[287:256]),
      .cfg_period (period_ff),
      .cfg_factor (factor_ff),
      .status     (status),
      .result     (result)
   );

endmodule

// ===== sim/tb_pow_difficulty_retarget.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pow_difficulty_retarget
// Self-checking bench for the difficulty retarget block. Retarget requests are
// streamed in under several period and factor settings. A scoreboard scales
// each accepted target on its own and compares every returned target word and
// the valid flag in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pow_difficulty_retarget import pdr_pkg::*; ();

   localparam int          CYCLE_LIMIT  = 2000000;
   localparam int          PHASE_ITEMS  = 205;
   localparam int          NUM_SETTINGS = 8;
   localparam logic [63:0] RATIO_CAP    = 64'd1000000;
   localparam logic [255:0] POW_CEILING = {24'h7fffff, 232'd0};

   typedef struct packed {
      logic [255:0] tgt;
      logic         ok;
   } retarget_type;

   // --------------------------------------------------------------------------
   // scoreboard: own copy of the registers, expected targets in arrival order
   // --------------------------------------------------------------------------
   class retarget_scoreboard;
      logic [31:0]  period;
      logic [7:0]   factor;
      retarget_type expected_targets[$];
      int           errors;
      int           n_noted;
      int           n_checked;

      function new();
         period    = PERIOD_RESET;
         factor    = FACTOR_RESET;
         errors    = 0;
         n_noted   = 0;
         n_checked = 0;
      endfunction

      function void set_reg(logic [0:0] idx, logic [31:0] data);
         if (idx == CSR_IDX_PERIOD) begin
            period = data;
         end else begin
            factor = data[7:0];
         end
      endfunction

      function int pending();
         return expected_targets.size();
      endfunction

      // scale prev by the clamped elapsed/period ratio
      function retarget_type scale_target(logic [255:0] prev, logic [31:0] elapsed);
         logic [63:0]        per;
         logic [63:0]        fac;
         logic [63:0]        hi_clamp;
         logic [63:0]        lo_clamp;
         logic [63:0]        num;
         logic [63:0]        den;
         logic signed [63:0] et;
         logic [255:0]       t;
         retarget_type       r;
         per      = (period == 0) ? 64'd1 : 64'(period);
         fac      = (factor == 0) ? 64'd1 : 64'(factor);
         hi_clamp = per * fac;
         lo_clamp = per / fac;
         r.tgt    = '0;
         r.ok     = 1'b0;
         if (prev == '0) return r;
         et = 64'(signed'(elapsed));
         if (et > signed'(hi_clamp)) begin
            num = hi_clamp;
         end else if (et < signed'(lo_clamp)) begin
            num = lo_clamp;
         end else begin
            num = et;
         end
         den = per;
         // joint halving keeps the ratio inside 32 bits
         while (num > RATIO_CAP && den > 1) begin
            num = num >> 1;
            den = den >> 1;
         end
         num = num & 64'hffffffff;
         den = den & 64'hffffffff;
         if (den == 0) den = 1;
         t = prev;
         if (num > den) begin
            t = t * 256'(num);
            t = t / 256'(den);
         end else begin
            t = t / 256'(den);
            t = t * 256'(num);
         end
         if (t > POW_CEILING) t = POW_CEILING;
         r.tgt = t;
         r.ok  = 1'b1;
         return r;
      endfunction

      function void note_request(logic [255:0] prev, logic [31:0] elapsed);
         expected_targets.push_back(scale_target(prev, elapsed));
         n_noted++;
      endfunction

      function void check_result(logic [255:0] got_tgt, logic got_ok);
         retarget_type want;
         if (expected_targets.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, target %h valid %b",
                     $time, got_tgt, got_ok);
            return;
         end
         want = expected_targets.pop_front();
         n_checked++;
         for (int w = 0; w < 4; w++) begin
            if (want.tgt[64*w +: 64] !== got_tgt[64*w +: 64]) begin
               errors++;
               $display("%0t: new_target_w%0d expected %h actual %h", $time, w,
                        want.tgt[64*w +: 64], got_tgt[64*w +: 64]);
            end
         end
         if (want.ok !== got_ok) begin
            errors++;
            $display("%0t: target_valid expected %b actual %b", $time, want.ok, got_ok);
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [287:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [255:0]  rsp_tdata;
   logic [0:0]    rsp_tuser;
   logic          csr_we = 1'b0;
   logic [0:0]    csr_index = CSR_IDX_PERIOD;
   logic [31:0]   csr_wdata = '0;

   retarget_scoreboard sb;
   logic          quiet = 1'b0;
   int            cycles = 0;

   pow_difficulty_retarget i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random back-pressure, check each transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser[0]);
      end
      rsp_tready <= quiet || ($urandom_range(99) >= 26);
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic push_retarget(logic [255:0] prev, logic [31:0] elapsed);
      while (!quiet && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {elapsed, prev};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(prev, elapsed);
   endtask

   // hold off until every expected result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write, then the write enable is taken low again
   task automatic write_csr(logic [0:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   function automatic logic [255:0] gen_target();
      logic [255:0] v;
      v = {$urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom()};
      case ($urandom_range(0, 19))
         0:       v = '0;
         1:       v = '1;
         2:       v = 256'd1 << $urandom_range(0, 255);
         3:       v = v >> $urandom_range(0, 255);
         4:       v = POW_CEILING - 256'($urandom_range(0, 3)) + 256'($urandom_range(0, 3));
         5:       v = v >> 192;
         6:       ;
         default: v = v >> $urandom_range(8, 64);
      endcase
      return v;
   endfunction

   // elapsed times spread around the clamp window of the current setting
   function automatic logic [31:0] gen_elapsed();
      logic [63:0] per;
      logic [63:0] fac;
      logic [63:0] e;
      per = (sb.period == 0) ? 64'd1 : 64'(sb.period);
      fac = (sb.factor == 0) ? 64'd1 : 64'(sb.factor);
      case ($urandom_range(0, 9))
         0:       e = 64'($urandom());
         1:       e = 64'h80000000;
         2:       e = 64'h7fffffff;
         3:       e = 64'd0;
         4:       e = 64'd0 - 64'($urandom_range(1, 5000));
         5:       e = per / fac + 64'($urandom_range(0, 2)) - 64'd1;
         6:       e = per * fac + 64'($urandom_range(0, 2)) - 64'd1;
         default: e = per * 64'($urandom_range(0, 4 * fac + 4)) / 4
                      + 64'($urandom_range(0, 7));
      endcase
      return e[31:0];
   endfunction

   // extremes, clamp edges, limit edges and zero targets at reset settings
   task automatic run_directed();
      push_retarget(256'd1, 32'd1209600);
      push_retarget('1, 32'h7fffffff);
      push_retarget('1, 32'h80000000);
      push_retarget(POW_CEILING, 32'd1209600);
      push_retarget(POW_CEILING + 256'd1, 32'd1209600);
      push_retarget(POW_CEILING, 32'd1209601);
      push_retarget('0, 32'd1209600);
      push_retarget('0, 32'hffffffff);
      push_retarget(256'd1, 32'd302400);
      push_retarget(256'd1 << 200, 32'd302399);
      push_retarget(256'd1 << 190, 32'd4838400);
      push_retarget(256'd1 << 190, 32'd4838401);
      push_retarget(256'd1 << 64, 32'd0);
      push_retarget(256'd1 << 128, 32'hffffffff);
      push_retarget(256'd1 << 192, 32'd600000);
      push_retarget({192'd0, 64'hffffffffffffffff}, 32'd2400000);
      push_retarget({64'h0000ffffffffffff, 192'd0}, 32'd900000);
      push_retarget(256'd3, 32'd1209599);
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         push_retarget(gen_target(), gen_elapsed());
      end
   endtask

   initial begin
      logic [31:0] periods [NUM_SETTINGS];
      logic [7:0]  factors [NUM_SETTINGS];
      sb = new();
      periods = '{32'd1, 32'd0, 32'hffffffff, 32'd600, 32'd1, 32'd0, 32'd10, 32'd1209600};
      factors = '{8'd1, 8'd0, 8'd255, 8'd4, 8'd255, 8'd0, 8'd3, 8'd4};
      // one setting drawn at random
      periods[5] = $urandom_range(1, 32'hffffffff);
      factors[5] = 8'($urandom_range(2, 255));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(PHASE_ITEMS);

      for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
         drain();
         write_csr(CSR_IDX_PERIOD, periods[ph]);
         write_csr(CSR_IDX_FACTOR, ($urandom() & 32'hffffff00) | 32'(factors[ph]));
         // no idling on either side for the widest setting
         quiet = (ph == 2);
         if (ph == 3) begin
            run_random(PHASE_ITEMS / 2);
            drain();
            run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            run_random(PHASE_ITEMS);
         end
      end
      quiet = 1'b0;

      // wind down: every result back, then a little slack
      drain();
      repeat (150) @(posedge clock);

      $display("covered %0d retarget requests over %0d register settings",
               sb.n_noted, NUM_SETTINGS + 1);
      $display("checked %0d results, %0d mismatches", sb.n_checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pdr_pkg.sv
rtl/pdr_datapath.sv
rtl/pdr_ctrl.sv
rtl/pow_difficulty_retarget.sv
sim/tb_pow_difficulty_retarget.sv
